// ===== hw/rtl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Request/response structs, op codes and cell control. No dependencies.
`default_nettype none

package ole_pkg;

    localparam int ITEM_W = 32;
    localparam int POS_W  = 5;
    localparam int MASK_W = 32;

    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_REMOVE   = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [ITEM_W-1:0] item_value;
        logic [POS_W-1:0]  position;
    } t_cmd;

    typedef struct packed {
        logic             success;
        logic             full_refused;
        logic [POS_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_list_engine.sv =====
// Ordered list engine top level: control, count, mask register, cell chain.
// Depends on ole_pkg and ole_cell.
//
// Usage:
//   Command channel (i_cmd_valid/o_cmd_ready, i_cmd) carries one request:
//   append, insert at position, contains or remove first match. Response
//   channel (o_rsp_valid/i_rsp_ready, o_rsp) returns one result per request
//   with success, full_refused and the entry count after the request.
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data) writes the match
//   mask; it is always ready. Write it only while the engine is idle.
//   The response is registered and is valid in the cycle after the request is
//   taken. Throughput: one request per cycle; all cells compare and shift in
//   the same cycle, and the first-match flag ripples down the cell chain.
//   A stalled receiver holds the response register; a new request is taken
//   in the cycle the pending response leaves, so the command side stalls
//   only while a response waits.
//   Reset: count clears to zero (list empty), mask goes to all ones. Entry
//   storage is not cleared; only positions below the count are ever used.
`default_nettype none

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire t_cmd              i_cmd,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output t_rsp                   o_rsp,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [MASK_W-1:0] i_cfg_data
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VEXT_W  = (VALUE_BITS > ITEM_W) ? VALUE_BITS : ITEM_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic              w_accept;
    logic [VEXT_W-1:0] w_item_ext;
    logic [VEXT_W-1:0] w_mask_ext;
    logic [VALUE_BITS-1:0] w_item;
    logic [VALUE_BITS-1:0] w_mask;
    logic              w_is_add;
    logic              w_is_rem;
    logic [CMP_W-1:0]  w_pos_c;
    logic [CMP_W-1:0]  w_count_c;
    logic [CMP_W-1:0]  w_ncount_c;
    logic              w_pos_bad;
    logic              w_full;
    logic              w_add_ok;
    logic              w_hit;
    t_cell_ctl         w_ctl;

    logic [VALUE_BITS-1:0] w_val   [CAPACITY];
    logic                  w_found [CAPACITY+1];

    assign o_cfg_ready = 1'b1;
    assign o_cmd_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_cmd_valid && o_cmd_ready;

    assign w_item_ext = VEXT_W'(i_cmd.item_value);
    assign w_mask_ext = VEXT_W'(r_mask);
    assign w_item     = w_item_ext[VALUE_BITS-1:0];
    assign w_mask     = w_mask_ext[VALUE_BITS-1:0];

    assign w_is_add  = (i_cmd.op == OP_APPEND) || (i_cmd.op == OP_INSERT);
    assign w_is_rem  = (i_cmd.op == OP_REMOVE);
    assign w_count_c = CMP_W'(r_count);
    assign w_pos_c   = (i_cmd.op == OP_APPEND) ? w_count_c : CMP_W'(i_cmd.position);
    assign w_pos_bad = w_pos_c > w_count_c;
    assign w_full    = (r_count == CAP_C);
    assign w_add_ok  = w_is_add && !w_pos_bad && !w_full;
    assign w_hit     = w_found[CAPACITY];

    assign w_ctl.ins = w_accept && w_add_ok;
    assign w_ctl.rem = w_accept && w_is_rem;

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem && w_hit) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_ncount_c = CMP_W'(n_count);

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left;
        logic [VALUE_BITS-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_item;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        ole_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_pos         (w_pos_c[CNT_W-1:0]),
            .i_count       (r_count),
            .i_item        (w_item),
            .i_mask        (w_mask),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .i_found       (w_found[g]),
            .o_value       (w_val[g]),
            .o_found       (w_found[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '1;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp.success      <= w_is_add ? w_add_ok : w_hit;
            r_rsp.full_refused <= w_is_add && !w_pos_bad && w_full;
            r_rsp.entry_count  <= w_ncount_c[POS_W-1:0];
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // count stays within the list bound
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("list count above capacity");

    // refused and succeeded are exclusive
    a_rsp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.success && o_rsp.full_refused))
        else $error("response both successful and refused");

    // a full refusal only happens on a full list, and leaves it unchanged
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!o_rsp.full_refused ||
                      ($past(r_count) == CAP_C && r_count == CAP_C)))
        else $error("full refusal on a list that was not full");

    // a request without success leaves the count alone
    a_fail_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_rsp.success || r_count == $past(r_count)))
        else $error("count changed on an unsuccessful request");

endmodule

`default_nettype wire

// ===== hw/rtl/ole_cell.sv =====
// One list position: holds an entry, compares it, shifts with its neighbors.
// Depends on ole_pkg (t_cell_ctl).
`default_nettype none

module ole_cell
    import ole_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 5,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [CNT_W-1:0]      i_pos,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire logic [VALUE_BITS-1:0] i_item,
    input  wire logic [VALUE_BITS-1:0] i_mask,
    input  wire logic [VALUE_BITS-1:0] i_left_value,
    input  wire logic [VALUE_BITS-1:0] i_right_value,
    input  wire logic                  i_found,
    output logic [VALUE_BITS-1:0]      o_value,
    output logic                       o_found
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_INDEX);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  w_match;

    assign w_match = (IDX < i_count) && !(|((r_value ^ i_item) & i_mask));
    assign o_found = i_found | w_match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (IDX == i_pos) begin
                n_value = i_item;
            end else if (IDX > i_pos) begin
                n_value = i_left_value;
            end
        end else if (i_ctl.rem && o_found) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for ordered_list_engine: directed table, then random command phases.
// Checks each response against a typed-in or predicted one. Depends on ole_pkg and RTL.
`timescale 1ns / 100ps

module tb;
    import ole_pkg::*;

    localparam int LIST_CAP = 16;

    typedef struct {
        bit                is_cfg;
        t_cmd              cmd;
        logic [MASK_W-1:0] mask;
        bit                known;
        t_rsp              rsp;
    } t_stim_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    t_cmd              cmd = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    t_rsp              rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MASK_W-1:0] cfg_data = '0;

    // known directed rows carry a typed-in response
    bit                cmd_known = 1'b0;
    t_rsp              cmd_known_rsp = '0;

    // list predictor state
    logic [ITEM_W-1:0] list_vals [LIST_CAP];
    int                list_len = 0;
    logic [MASK_W-1:0] cur_mask = '1;

    t_rsp              pending_rsp [$];
    t_stim_row         script [$];
    int                mismatches = 0;
    int                cmd_gap_max = 4;
    int                rsp_gap_max = 4;

    ordered_list_engine i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_rsp predict_list_op(input t_cmd c);
        t_rsp r;
        int   pos;
        int   hit;
        int   i;
        r = '0;
        hit = -1;
        if (c.op == OP_APPEND || c.op == OP_INSERT) begin
            pos = (c.op == OP_APPEND) ? list_len : int'(c.position);
            if (pos > list_len) begin
                r.success = 1'b0;
            end else if (list_len >= LIST_CAP) begin
                r.full_refused = 1'b1;
            end else begin
                for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
                list_vals[pos] = c.item_value;
                list_len++;
                r.success = 1'b1;
            end
        end else begin
            for (i = list_len - 1; i >= 0; i--)
                if (((list_vals[i] ^ c.item_value) & cur_mask) == '0) hit = i;
            if (hit >= 0) begin
                r.success = 1'b1;
                if (c.op == OP_REMOVE) begin
                    for (i = hit; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
        end
        r.entry_count = POS_W'(list_len);
        return r;
    endfunction

    function automatic void add_cmd(input logic [1:0] op, input logic [ITEM_W-1:0] v,
                                    input int pos);
        t_stim_row row;
        row = '{is_cfg: 1'b0, cmd: '0, mask: '0, known: 1'b0, rsp: '0};
        row.cmd.op = op;
        row.cmd.item_value = v;
        row.cmd.position = POS_W'(pos);
        script.push_back(row);
    endfunction

    function automatic void add_known(input logic [1:0] op, input logic [ITEM_W-1:0] v,
                                      input int pos, input bit s, input bit f, input int n);
        add_cmd(op, v, pos);
        script[$].known = 1'b1;
        script[$].rsp.success = s;
        script[$].rsp.full_refused = f;
        script[$].rsp.entry_count = POS_W'(n);
    endfunction

    function automatic void add_mask(input logic [MASK_W-1:0] m);
        t_stim_row row;
        row = '{is_cfg: 1'b1, cmd: '0, mask: m, known: 1'b0, rsp: '0};
        script.push_back(row);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_cmd(input t_cmd c, input bit known, input t_rsp r);
        int gap;
        gap = $urandom_range(0, cmd_gap_max);
        if (gap > 0) begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd = c;
        cmd_known = known;
        cmd_known_rsp = r;
        cmd_valid = 1'b1;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] m);
        cmd_valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_data = m;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // predictor update and response check
    always @(posedge clk) begin
        t_rsp want;
        t_rsp pred;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) cur_mask = cfg_data;
            if (cmd_valid && cmd_ready) begin
                pred = predict_list_op(cmd);
                pending_rsp.push_back(cmd_known ? cmd_known_rsp : pred);
            end
            if (rsp_valid && rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected rsp: s=%0d f=%0d n=%0d",
                                 rsp.success, rsp.full_refused, rsp.entry_count);
                end else begin
                    want = pending_rsp.pop_front();
                    if (rsp.success !== want.success || rsp.full_refused !== want.full_refused
                        || rsp.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("rsp mismatch: exp s=%0d f=%0d n=%0d got s=%0d f=%0d n=%0d",
                                     want.success, want.full_refused, want.entry_count,
                                     rsp.success, rsp.full_refused, rsp.entry_count);
                    end
                end
            end
        end
    end

    // response side backpressure
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, rsp_gap_max);
            if (gap > 0) begin
                rsp_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int                i;
        int                ph;
        int                n;
        int                k;
        int                add_pct;
        t_cmd              c;
        logic [ITEM_W-1:0] pool [8];

        // directed table
        add_known(OP_CONTAINS, 32'h0000_0000, 0, 0, 0, 0);
        add_known(OP_REMOVE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_known(OP_INSERT, 32'h0000_1234, 1, 0, 0, 0);
        add_known(OP_INSERT, 32'h0000_0000, 0, 1, 0, 1);
        add_known(OP_APPEND, 32'hFFFF_FFFF, 0, 1, 0, 2);
        add_known(OP_INSERT, 32'hA5A5_A5A5, 2, 1, 0, 3);
        add_cmd(OP_INSERT, 32'h5A5A_5A5A, 1);
        add_known(OP_CONTAINS, 32'hFFFF_FFFF, 31, 1, 0, 4);
        add_known(OP_CONTAINS, 32'h1234_5678, 0, 0, 0, 4);
        add_known(OP_REMOVE, 32'h5A5A_5A5A, 0, 1, 0, 3);
        add_known(OP_INSERT, 32'h0000_0077, 31, 0, 0, 3);
        for (i = 0; i < 13; i++)
            add_known(OP_APPEND, 32'h1000_0000 + i, 0, 1, 0, 4 + i);
        add_known(OP_APPEND, 32'h0000_0BAD, 0, 0, 1, 16);
        add_known(OP_INSERT, 32'h0000_0BAD, 0, 0, 1, 16);
        add_known(OP_INSERT, 32'h0000_0BAD, 16, 0, 1, 16);
        add_known(OP_INSERT, 32'h0000_0BAD, 17, 0, 0, 16);
        add_mask(32'h0000_0000);
        add_known(OP_CONTAINS, 32'h0BAD_F00D, 0, 1, 0, 16);
        add_known(OP_REMOVE, 32'h0BAD_F00D, 0, 1, 0, 15);
        add_mask(32'hFFFF_FFFF);
        add_cmd(OP_REMOVE, 32'h1000_0005, 0);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[j]) begin
            if (script[j].is_cfg) write_mask(script[j].mask);
            else issue_cmd(script[j].cmd, script[j].known, script[j].rsp);
        end

        // random phases
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_mask(32'hFFFF_FFFF);
                2: write_mask(32'h0000_000F);
                3: write_mask(32'h0000_0000);
                5: write_mask(32'hFFFF_0000);
                7: write_mask(32'hFFFF_FFFF);
                default: write_mask($urandom());
            endcase
            cmd_gap_max = (ph % 4 == 0 || ph % 4 == 1) ? 0 : 4;
            rsp_gap_max = (ph % 4 == 0 || ph % 4 == 2) ? 0 : 4;
            pool[0] = '0;
            pool[1] = '1;
            for (i = 2; i < 8; i++) pool[i] = $urandom();
            add_pct = 50;
            for (n = 0; n < 200; n++) begin
                if (n % 40 == 0) add_pct = $urandom_range(25, 75);
                c = '0;
                if ($urandom_range(0, 99) < add_pct)
                    c.op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
                else
                    c.op = ($urandom_range(0, 1) != 0) ? OP_REMOVE : OP_CONTAINS;
                k = $urandom_range(0, 9);
                if (k < 5)
                    c.item_value = pool[$urandom_range(0, 7)];
                else if (k < 7)
                    c.item_value = pool[$urandom_range(0, 7)] ^ ($urandom() & ~cur_mask);
                else
                    c.item_value = $urandom();
                if ($urandom_range(0, 6) == 0)
                    c.position = POS_W'($urandom_range(0, 31));
                else
                    c.position = POS_W'($urandom_range(0, list_len));
                issue_cmd(c, 1'b0, '0);
            end
        end

        cmd_valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
